/* hw/rtl/tfq_pkg.sv */
package tfq_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned MAX_RUN = 64;

  // in_tdata: entry_data, byte_count, entry_tag, padded to whole bytes
  localparam int unsigned IN_DATA_W  = ((DATA_W + LEN_W + TAG_W + 7) / 8) * 8;
  // out_tdata: out_data, out_tag, entry_count, is_full, is_empty
  localparam int unsigned OUT_DATA_W = ((DATA_W + TAG_W + COUNT_W + 2 + 7) / 8) * 8;
  localparam int unsigned OUT_USER_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd1;

  localparam logic [COUNT_W-1:0] DEPTH_RESET = 7'd64;
  localparam logic [LEN_W-1:0]   WIDTH_RESET = 4'd8;
  localparam logic [LEN_W-1:0]   LEN_ALL     = 4'd8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_FLUSH = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_REFUSED  = 2'd1,
    ST_TOO_LONG = 2'd2
  } result_t;

  typedef struct packed {
    logic    push;      // store entry at tail
    logic    pop;       // take head: count down, latch length
    logic    flush;     // start flush: count to zero, arm run counter
    logic    load_st;   // load a result without entry
    result_t st_code;
    logic    load_ent;  // load a result from the store, step head
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic len_bad;
    logic rem_zero;
  } dp_sts_t;

  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      if (LEN_W'(i) < n) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/tfq_ram.sv */
module tfq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/tfq_datapath.sv */
module tfq_datapath #(
  parameter int unsigned LIM         = 64,
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tfq_pkg::dp_cmd_t                  cmd,
  output tfq_pkg::dp_sts_t                  sts,
  input  logic [tfq_pkg::DATA_W-1:0]        entry_data,
  input  logic [tfq_pkg::LEN_W-1:0]         byte_count,
  input  logic [tfq_pkg::TAG_W-1:0]         entry_tag,
  input  logic                              cfg_we,
  input  logic [tfq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tfq_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic [tfq_pkg::DATA_W-1:0]        res_data,
  output logic [tfq_pkg::TAG_W-1:0]         res_tag,
  output tfq_pkg::result_t                  res_status,
  output logic                              res_has,
  output logic                              res_last,
  output logic [tfq_pkg::COUNT_W-1:0]       res_count,
  output logic                              res_full,
  output logic                              res_empty
);

  localparam int unsigned PW = $clog2(LIM);
  localparam int unsigned EW = ENTRY_BYTES * 8;
  localparam int unsigned RW = EW + tfq_pkg::TAG_W;

  logic [PW-1:0]                  head_r, head_nxt, tail_r, tail_nxt;
  logic [tfq_pkg::COUNT_W-1:0]    count_r, count_nxt, rem_r, rem_nxt;
  logic [tfq_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [tfq_pkg::COUNT_W-1:0]    depth_r;
  logic [tfq_pkg::LEN_W-1:0]      width_r;
  logic [tfq_pkg::COUNT_W-1:0]    eff_depth;
  logic [tfq_pkg::LEN_W-1:0]      eff_width;
  logic [tfq_pkg::DATA_W-1:0]     data_r, tag_r;
  tfq_pkg::result_t               status_r;
  logic                           has_r, last_r;
  logic [PW-1:0]                  ram_addr;
  logic [RW-1:0]                  ram_wdata, ram_rdata;
  logic [tfq_pkg::DATA_W-1:0]     push_masked;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(LIM - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    if (depth_r == '0) begin
      eff_depth = 7'd1;
    end else if (depth_r > 7'(LIM)) begin
      eff_depth = 7'(LIM);
    end else begin
      eff_depth = depth_r;
    end
    eff_width = (width_r > 4'(ENTRY_BYTES)) ? 4'(ENTRY_BYTES) : width_r;
  end

  assign sts.full     = (count_r >= eff_depth);
  assign sts.empty    = (count_r == '0);
  assign sts.len_bad  = (byte_count > eff_width);
  assign sts.rem_zero = (rem_r == '0);

  assign push_masked = entry_data & tfq_pkg::byte_mask(byte_count);
  assign ram_addr    = cmd.push ? tail_r : head_r;
  assign ram_wdata   = {entry_tag, push_masked[EW-1:0]};

  tfq_ram #(
    .WIDTH(RW),
    .DEPTH(LIM)
  ) u_store (
    .clk  (clk),
    .we   (cmd.push),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    rem_nxt   = rem_r;
    len_nxt   = len_r;
    if (cmd.push) begin
      tail_nxt  = ptr_inc(tail_r);
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
      rem_nxt   = 7'd1;
      len_nxt   = byte_count;
    end
    if (cmd.flush) begin
      count_nxt = '0;
      rem_nxt   = count_r;
      len_nxt   = tfq_pkg::LEN_ALL;
    end
    if (cmd.load_ent) begin
      head_nxt = ptr_inc(head_r);
      rem_nxt  = rem_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      rem_r   <= '0;
      depth_r <= tfq_pkg::DEPTH_RESET;
      width_r <= tfq_pkg::WIDTH_RESET;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      rem_r   <= rem_nxt;
      if (cfg_we && cfg_index == tfq_pkg::CFG_DEPTH) begin
        depth_r <= cfg_data;
      end
      if (cfg_we && cfg_index == tfq_pkg::CFG_WIDTH) begin
        width_r <= cfg_data[tfq_pkg::LEN_W-1:0];
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (cmd.load_st) begin
      data_r   <= '0;
      tag_r    <= '0;
      status_r <= cmd.st_code;
      has_r    <= 1'b0;
      last_r   <= 1'b1;
    end else if (cmd.load_ent) begin
      data_r   <= tfq_pkg::DATA_W'(ram_rdata[EW-1:0]) & tfq_pkg::byte_mask(len_r);
      tag_r    <= ram_rdata[RW-1:EW];
      status_r <= tfq_pkg::ST_DONE;
      has_r    <= 1'b1;
      last_r   <= (rem_r == 7'd1);
    end
  end

  assign res_data   = data_r;
  assign res_tag    = tag_r;
  assign res_status = status_r;
  assign res_has    = has_r;
  assign res_last   = last_r;
  assign res_count  = count_r;
  assign res_full   = sts.full;
  assign res_empty  = sts.empty;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 7'(LIM))
    else $error("entry count beyond storage");

  a_run_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_ent |-> rem_r != '0)
    else $error("entry load with no entries left in run");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && rem_r == '0) |-> head_r == tail_r)
    else $error("head and tail disagree on empty queue");

endmodule

/* hw/rtl/tfq_ctrl.sv */
module tfq_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [tfq_pkg::REQ_W-1:0]  req,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output tfq_pkg::dp_cmd_t           cmd,
  input  tfq_pkg::dp_sts_t           sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_LOAD = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.st_code = tfq_pkg::ST_DONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt   = S_OUT;
          cmd.load_st = 1'b1;
          case (req)
            tfq_pkg::REQ_PUSH: begin
              if (sts.full) begin
                cmd.st_code = tfq_pkg::ST_REFUSED;
              end else if (sts.len_bad) begin
                cmd.st_code = tfq_pkg::ST_TOO_LONG;
              end else begin
                cmd.push = 1'b1;
              end
            end
            tfq_pkg::REQ_POP: begin
              if (sts.empty) begin
                cmd.st_code = tfq_pkg::ST_REFUSED;
              end else if (sts.len_bad) begin
                cmd.st_code = tfq_pkg::ST_TOO_LONG;
              end else begin
                cmd.load_st = 1'b0;
                cmd.pop     = 1'b1;
                state_nxt   = S_READ;
              end
            end
            tfq_pkg::REQ_FLUSH: begin
              if (!sts.empty) begin
                cmd.load_st = 1'b0;
                cmd.flush   = 1'b1;
                state_nxt   = S_READ;
              end
            end
            default: ;  // unknown request: plain done result
          endcase
        end
      end
      S_READ: state_nxt = S_LOAD;  // store read of the head in flight
      S_LOAD: begin
        cmd.load_ent = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = sts.rem_zero ? S_IDLE : S_READ;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !out_tready) |=> state_r == S_OUT)
    else $error("pending result dropped");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_tready && sts.rem_zero) |=> state_r == S_IDLE)
    else $error("run did not return to idle");

  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push, cmd.pop, cmd.flush, cmd.load_ent}))
    else $error("conflicting datapath commands");

endmodule

/* hw/rtl/tagged_fifo_queue.sv */
// Push, refused and unknown requests give their result in the cycle after the input
// transfer; a pop result passes through store read, load and output in turn.
// A new request is taken only in idle, once the last result has left on out_tready; a
// flush streams its entries one at a time, paced by the single-port store's registered read.
// Reset (rst_n, synchronous): queue empty, depth_in_use 64, width_in_use 8; the
// store needs no clearing pass, as only entries below the count are ever read.
module tagged_fifo_queue #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // entry_data[63:0], byte_count[67:64], entry_tag[131:68], zero pad
  input  logic [tfq_pkg::IN_DATA_W-1:0]      in_tdata,
  // req_type
  input  logic [tfq_pkg::REQ_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_data[63:0], out_tag[127:64], entry_count[134:128], is_full[135],
  // is_empty[136], zero pad
  output logic [tfq_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status[1:0], has_entry[2]
  output logic [tfq_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tfq_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tfq_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned LIM = (DEPTH < tfq_pkg::MAX_RUN) ? DEPTH : tfq_pkg::MAX_RUN;

  tfq_pkg::dp_cmd_t                 cmd;
  tfq_pkg::dp_sts_t                 sts;
  logic [tfq_pkg::DATA_W-1:0]       res_data;
  logic [tfq_pkg::TAG_W-1:0]        res_tag;
  tfq_pkg::result_t                 res_status;
  logic                             res_has, res_full, res_empty;
  logic [tfq_pkg::COUNT_W-1:0]      res_count;

  assign cfg_ready = 1'b1;

  tfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .req       (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tfq_datapath #(
    .LIM        (LIM),
    .ENTRY_BYTES(ENTRY_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .entry_data(in_tdata[63:0]),
    .byte_count(in_tdata[67:64]),
    .entry_tag (in_tdata[131:68]),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_data  (res_data),
    .res_tag   (res_tag),
    .res_status(res_status),
    .res_has   (res_has),
    .res_last  (out_tlast),
    .res_count (res_count),
    .res_full  (res_full),
    .res_empty (res_empty)
  );

  assign out_tdata = tfq_pkg::OUT_DATA_W'({res_empty, res_full, res_count, res_tag, res_data});
  assign out_tuser = {res_has, res_status};

endmodule
